@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/atan_pkg.sv @@
package atan_pkg;

   localparam int DefInWidth     = 16;
   localparam int DefOutFracBits = 13;

   localparam int RatioBits = 17;
   localparam int CoefBits  = 34;

   localparam logic signed [CoefBits-1:0] C1 = 34'sd338;
   localparam logic signed [CoefBits-1:0] C2 = 34'sd1073713441;
   localparam logic signed [CoefBits-1:0] C3 = 34'sd158312570;
   localparam logic signed [CoefBits-1:0] C4 = 34'sd332840025;
   localparam logic signed [CoefBits-1:0] C5 = 34'sd54011108;
   localparam logic signed [CoefBits-1:0] C6 = 34'sd157951624;
   localparam logic signed [CoefBits-1:0] C7 = 34'sd691988024;
   localparam logic signed [CoefBits-1:0] OneQ30    = 34'sd1073741824;
   localparam logic signed [CoefBits-1:0] PiQ30     = 34'sd3373259426;
   localparam logic signed [CoefBits-1:0] HalfPiQ30 = 34'sd1686629713;

   typedef struct packed {
      logic swap;
      logic x_neg;
      logic y_neg;
   } quad_type;

   // Horner step: acc + round(r * c / 2^16), half up.
   function automatic logic signed [CoefBits-1:0] horner_step(
      input logic signed [CoefBits-1:0] acc,
      input logic [RatioBits-1:0]       r,
      input logic signed [CoefBits-1:0] c
   );
      logic signed [CoefBits+RatioBits:0] p;
      p = $signed({1'b0, r}) * c + (CoefBits+RatioBits+1)'(32768);
      return acc + CoefBits'(p >>> 16);
   endfunction

endpackage

@@ src/atan_div.sv @@
// Pipelined restoring divider: quot = (num + den/2) / den, one bit per stage.
module atan_div #(
   parameter int NumBits = 64,
   parameter int DenBits = 34,
   parameter int TagBits = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  logic [NumBits-1:0] in_num,
   input  logic [DenBits-1:0] in_den,
   input  logic [TagBits-1:0] in_tag,
   output logic               out_valid,
   output logic [NumBits-1:0] out_quot,
   output logic [TagBits-1:0] out_tag
);
   logic [NumBits-1:0] num_ff [NumBits+1];
   logic [DenBits-1:0] den_ff [NumBits+1];
   logic [DenBits:0]   rem_ff [NumBits+1];
   logic [TagBits-1:0] tag_ff [NumBits+1];
   logic [NumBits:0]   vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[NumBits-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         num_ff[0] <= in_num + NumBits'(in_den >> 1);
         den_ff[0] <= in_den;
         rem_ff[0] <= '0;
         tag_ff[0] <= in_tag;
      end
   end

   for (genvar i = 0; i < NumBits; i++) begin : g_stage
      logic [DenBits+1:0] trial_in;
      logic [DenBits:0]   rem_in;
      logic [NumBits-1:0] num_in;
      always_comb begin
         trial_in = {rem_ff[i], num_ff[i][NumBits-1]} - {2'b00, den_ff[i]};
         num_in   = {num_ff[i][NumBits-2:0], 1'b0};
         if (!trial_in[DenBits+1]) begin
            rem_in    = trial_in[DenBits:0];
            num_in[0] = 1'b1;
         end else begin
            rem_in = {rem_ff[i][DenBits-1:0], num_ff[i][NumBits-1]};
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            num_ff[i+1] <= num_in;
            rem_ff[i+1] <= rem_in;
            den_ff[i+1] <= den_ff[i];
            tag_ff[i+1] <= tag_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[NumBits];
   assign out_quot  = num_ff[NumBits];
   assign out_tag   = tag_ff[NumBits];
endmodule

@@ src/atan_poly.sv @@
// Magnitudes, ratio division and Horner evaluation, one register per step.
module atan_poly #(
   parameter int InWidth = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  enable,
   input  logic                                  in_valid,
   input  logic signed [InWidth-1:0]             in_x,
   input  logic signed [InWidth-1:0]             in_y,
   output logic                                  out_valid,
   output logic signed [atan_pkg::CoefBits-1:0]  out_num,
   output logic signed [atan_pkg::CoefBits-1:0]  out_den,
   output atan_pkg::quad_type                    out_quad
);
   import atan_pkg::*;
   `include "assert_macros.svh"

   localparam int MagBits  = InWidth + 1;
   localparam int RNumBits = MagBits + 17;
   localparam int QBits    = $bits(quad_type);

   logic             v0_ff;
   logic [MagBits-1:0] mx_ff, mn_ff;
   quad_type         q0_ff;
   logic [MagBits:0] ax_in, ay_in;

   always_comb begin
      ax_in = in_x[InWidth-1] ? (MagBits+1)'(-$signed({in_x[InWidth-1], in_x}))
                              : (MagBits+1)'({in_x[InWidth-1], in_x});
      ay_in = in_y[InWidth-1] ? (MagBits+1)'(-$signed({in_y[InWidth-1], in_y}))
                              : (MagBits+1)'({in_y[InWidth-1], in_y});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (enable) begin
         v0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         q0_ff.swap  <= ay_in > ax_in;
         q0_ff.x_neg <= in_x[InWidth-1];
         q0_ff.y_neg <= in_y[InWidth-1];
         mx_ff <= (ay_in > ax_in) ? ay_in[MagBits-1:0] : ax_in[MagBits-1:0];
         mn_ff <= (ay_in > ax_in) ? ax_in[MagBits-1:0] : ay_in[MagBits-1:0];
      end
   end

   // r = (mn*2^16 + mx/2) / mx; mx of zero gives all ones, masked below.
   logic             dv_valid;
   logic [RNumBits-1:0] dv_quot;
   logic [QBits:0]   dv_tag;

   atan_div #(.NumBits(RNumBits), .DenBits(MagBits), .TagBits(QBits + 1)) u_rdiv (
      .clock, .reset, .enable,
      .in_valid (v0_ff),
      .in_num   (RNumBits'({mn_ff, 16'd0})),
      .in_den   (mx_ff),
      .in_tag   ({q0_ff, mx_ff == '0}),
      .out_valid(dv_valid),
      .out_quot (dv_quot),
      .out_tag  (dv_tag)
   );

   logic [RatioBits-1:0] r_in;
   assign r_in = dv_tag[0] ? '0 : dv_quot[RatioBits-1:0];

   // Horner pipeline: stage k holds r, num and den partials.
   localparam int Steps = 4;
   logic [RatioBits-1:0]        r_ff   [Steps];
   logic signed [CoefBits-1:0]  n_ff   [Steps];
   logic signed [CoefBits-1:0]  d_ff   [Steps];
   quad_type                    q_ff   [Steps];
   logic [Steps-1:0]            hv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff <= '0;
      end else if (enable) begin
         hv_ff <= {hv_ff[Steps-2:0], dv_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         r_ff[0] <= r_in;
         q_ff[0] <= dv_tag[QBits:1];
         // round r*C5 first, then subtract
         n_ff[0] <= C4 - horner_step('0, r_in, C5);
         d_ff[0] <= horner_step(C6, r_in, C7);
         r_ff[1] <= r_ff[0];
         q_ff[1] <= q_ff[0];
         n_ff[1] <= horner_step(C3, r_ff[0], n_ff[0]);
         d_ff[1] <= horner_step(OneQ30, r_ff[0], d_ff[0]);
         r_ff[2] <= r_ff[1];
         q_ff[2] <= q_ff[1];
         n_ff[2] <= horner_step(C2, r_ff[1], n_ff[1]);
         d_ff[2] <= d_ff[1];
         r_ff[3] <= r_ff[2];
         q_ff[3] <= q_ff[2];
         n_ff[3] <= horner_step(C1, r_ff[2], n_ff[2]);
         d_ff[3] <= d_ff[2];
      end
   end

   assign out_valid = hv_ff[Steps-1];
   assign out_num   = n_ff[Steps-1];
   assign out_den   = d_ff[Steps-1];
   assign out_quad  = q_ff[Steps-1];

   `ASSERT_IMPLY(a_den_min, clock, reset, out_valid, out_den >= OneQ30,
      "denominator below one")
   `ASSERT_IMPLY(a_ratio_max, clock, reset, dv_valid && !dv_tag[0],
      dv_quot <= RNumBits'(65536), "ratio above one")
endmodule

@@ src/atan_quad.sv @@
// Rational division, quadrant mapping, saturation and output rounding.
module atan_quad #(
   parameter int OutFracBits = 13
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 enable,
   input  logic                                 in_valid,
   input  logic signed [atan_pkg::CoefBits-1:0] in_num,
   input  logic signed [atan_pkg::CoefBits-1:0] in_den,
   input  atan_pkg::quad_type                   in_quad,
   output logic                                 out_valid,
   output logic signed [OutFracBits+2:0]        out_angle
);
   import atan_pkg::*;
   `include "assert_macros.svh"

   localparam int NumBits = CoefBits + 30;
   localparam int QBits   = $bits(quad_type);
   localparam int Shift   = 30 - OutFracBits;
   localparam int OutBits = OutFracBits + 3;

   logic                 neg;
   logic [CoefBits-1:0]  mag;
   assign neg = in_num[CoefBits-1];
   assign mag = neg ? CoefBits'(-in_num) : CoefBits'(in_num);

   logic               dv_valid;
   logic [NumBits-1:0] dv_quot;
   logic [QBits:0]     dv_tag;

   atan_div #(.NumBits(NumBits), .DenBits(CoefBits), .TagBits(QBits + 1)) u_qdiv (
      .clock, .reset, .enable,
      .in_valid (in_valid),
      .in_num   ({mag, 30'd0}),
      .in_den   (in_den),
      .in_tag   ({in_quad, neg}),
      .out_valid(dv_valid),
      .out_quot (dv_quot),
      .out_tag  (dv_tag)
   );

   logic signed [CoefBits+1:0] res_in, r1, r2, r3;
   quad_type                   q;
   always_comb begin
      q      = dv_tag[QBits:1];
      res_in = dv_tag[0] ? -$signed((CoefBits+2)'(dv_quot[CoefBits-1:0]))
                         : $signed((CoefBits+2)'(dv_quot[CoefBits-1:0]));
      r1 = q.swap  ? (CoefBits+2)'(HalfPiQ30) - res_in : res_in;
      r2 = q.x_neg ? (CoefBits+2)'(PiQ30) - r1 : r1;
      r3 = q.y_neg ? -r2 : r2;
   end

   logic                       v1_ff, v2_ff;
   logic signed [CoefBits+1:0] res_ff;
   logic signed [CoefBits+1:0] sat_in;
   logic signed [OutBits-1:0]  ang_ff;

   always_comb begin
      sat_in = res_ff;
      if (res_ff > (CoefBits+2)'(PiQ30)) sat_in = (CoefBits+2)'(PiQ30);
      if (res_ff < -(CoefBits+2)'(PiQ30)) sat_in = -(CoefBits+2)'(PiQ30);
      sat_in = sat_in + (CoefBits+2)'(1 << (Shift - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= dv_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         res_ff <= r3;
         ang_ff <= OutBits'(sat_in >>> Shift);
      end
   end

   assign out_valid = v2_ff;
   assign out_angle = ang_ff;

   `ASSERT_NEXT(a_valid_flow, clock, reset, enable && dv_valid, v1_ff,
      "valid lost in output stage")
endmodule

@@ src/atan2_rational_approx.sv @@
// Four-quadrant arctangent. One word per clock in and out while rsp_tready
// does not stall. The pipeline is 1 magnitude stage, the ratio divider, 4
// Horner stages, the quotient divider and 2 output stages; the two dividers
// work one bit per stage and make up most of its depth. Any stall on
// rsp_tready freezes the whole pipeline, so a result waiting in the output
// register also holds off the next input word.
module atan2_rational_approx #(
   parameter int IN_WIDTH      = atan_pkg::DefInWidth,
   parameter int OUT_FRAC_BITS = atan_pkg::DefOutFracBits
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // x_value, y_value (lowest bits first), padded to bytes
   input  logic [((2*IN_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // angle, padded to bytes
   output logic [((OUT_FRAC_BITS+3+7)/8)*8-1:0] rsp_tdata
);
   import atan_pkg::*;
   `include "assert_macros.svh"

   localparam int OutBits = OUT_FRAC_BITS + 3;
   localparam int RspBits = ((OutBits + 7) / 8) * 8;

   logic enable;
   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   logic                        pv;
   logic signed [CoefBits-1:0]  pn, pd;
   quad_type                    pq;

   atan_poly #(.InWidth(IN_WIDTH)) u_poly (
      .clock, .reset, .enable,
      .in_valid (req_tvalid && req_tready),
      .in_x     ($signed(req_tdata[IN_WIDTH-1:0])),
      .in_y     ($signed(req_tdata[2*IN_WIDTH-1:IN_WIDTH])),
      .out_valid(pv),
      .out_num  (pn),
      .out_den  (pd),
      .out_quad (pq)
   );

   logic                      qv;
   logic signed [OutBits-1:0] ang;

   atan_quad #(.OutFracBits(OUT_FRAC_BITS)) u_quad (
      .clock, .reset, .enable,
      .in_valid (pv),
      .in_num   (pn),
      .in_den   (pd),
      .in_quad  (pq),
      .out_valid(qv),
      .out_angle(ang)
   );

   assign rsp_tvalid = qv;
   assign rsp_tdata  = RspBits'($unsigned(ang));

   `ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `ASSERT_IMPLY(a_ready, clock, reset, rsp_tvalid && !rsp_tready, !req_tready,
      "input taken during stall")
endmodule

@@ bench/tb_atan2_rational_approx.sv @@
module tb_atan2_rational_approx;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // x_value, y_value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // angle

   localparam int Latency = 107;

   atan2_rational_approx dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

   localparam longint unsigned Bias = 64'd1 << 62;

   function automatic longint rnd_shift(longint v, int sh);
      longint unsigned u;
      u = longint'(v) + Bias + (64'd1 << (sh - 1));
      return longint'(u >> sh) - longint'(Bias >> sh);
   endfunction

   function automatic logic [15:0] angle_of(logic signed [15:0] xv,
                                            logic signed [15:0] yv);
      longint x, y, ax, ay, mx, mn, r, num, den, res;
      longint unsigned mag;
      logic neg;
      x = xv; y = yv;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      mx = ax > ay ? ax : ay;
      mn = ax > ay ? ay : ax;
      r = 0;
      if (mx != 0) r = ((mn << 17) + mx) / (mx << 1);
      num = longint'(atan_pkg::C4) - rnd_shift(r * longint'(atan_pkg::C5), 16);
      num = longint'(atan_pkg::C3) + rnd_shift(r * num, 16);
      num = longint'(atan_pkg::C2) + rnd_shift(r * num, 16);
      num = longint'(atan_pkg::C1) + rnd_shift(r * num, 16);
      den = longint'(atan_pkg::C6) + rnd_shift(r * longint'(atan_pkg::C7), 16);
      den = longint'(atan_pkg::OneQ30) + rnd_shift(r * den, 16);
      neg = num < 0;
      mag = neg ? -num : num;
      mag = ((mag << 30) + (longint'(den) >> 1)) / longint'(den);
      res = neg ? -longint'(mag) : longint'(mag);
      if (ay > ax) res = longint'(atan_pkg::HalfPiQ30) - res;
      if (x < 0) res = longint'(atan_pkg::PiQ30) - res;
      if (y < 0) res = -res;
      if (res > longint'(atan_pkg::PiQ30)) res = atan_pkg::PiQ30;
      if (res < -longint'(atan_pkg::PiQ30)) res = -longint'(atan_pkg::PiQ30);
      return 16'(rnd_shift(res, 17));
   endfunction

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               known;
      logic [15:0]        angle;
   } vec_t;

   vec_t directed [] = '{
      '{16'sd0, 16'sd0, 1'b1, 16'd0},
      '{16'sd100, 16'sd0, 1'b1, 16'd0},
      '{-16'sd100, 16'sd0, 1'b1, 16'd25736},
      '{16'sd32767, 16'sd0, 1'b1, 16'd0},
      '{-16'sd32768, 16'sd0, 1'b1, 16'd25736},
      '{16'sd0, 16'sd32767, 1'b0, 16'd0},
      '{16'sd0, -16'sd32768, 1'b0, 16'd0},
      '{-16'sd32768, -16'sd1, 1'b0, 16'd0},
      '{-16'sd32768, -16'sd32768, 1'b0, 16'd0},
      '{16'sd32767, 16'sd32767, 1'b0, 16'd0},
      '{-16'sd32768, 16'sd32767, 1'b0, 16'd0},
      '{16'sd32767, -16'sd32768, 1'b0, 16'd0},
      '{16'sd1, 16'sd1, 1'b0, 16'd0},
      '{-16'sd1, -16'sd1, 1'b0, 16'd0},
      '{16'sd5, 16'sd100, 1'b0, 16'd0},
      '{-16'sd5, 16'sd100, 1'b0, 16'd0},
      '{-16'sd100, 16'sd5, 1'b0, 16'd0},
      '{-16'sd100, -16'sd5, 1'b0, 16'd0},
      '{16'sd100, -16'sd5, 1'b0, 16'd0},
      '{16'sd5, -16'sd100, 1'b0, 16'd0},
      '{-16'sd1, 16'sd0, 1'b1, 16'd25736},
      '{16'sd0, -16'sd1, 1'b0, 16'd0},
      '{-16'sd21846, 16'sd21845, 1'b0, 16'd0}
   };

   logic [15:0] pending_angles [$];
   int          fails = 0;
   bit          calm = 1'b0;
   bit          hold_rx = 1'b0;

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(logic signed [15:0] x, logic signed [15:0] y,
                            logic known, logic [15:0] angle);
      while (!calm && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_angles.push_back(known ? angle : angle_of(x, y));
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_val();
      case ($urandom_range(5))
         0: return 16'($urandom_range(7)) - 16'sd4;
         1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         2: return 16'($urandom_range(255));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int timer;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i])
         send_word(directed[i].x, directed[i].y, directed[i].known, directed[i].angle);
      for (int n = 0; n < 650; n++) begin
         if (n == 100) begin
            req_tvalid <= 1'b0;
            while (pending_angles.size() != 0) @(negedge clock);
         end
         calm = (n >= 300 && n < 420);
         hold_rx = (n >= 450 && n < 600);
         send_word(rand_val(), rand_val(), 1'b0, 16'd0);
      end
      req_tvalid <= 1'b0;
      hold_rx = 1'b0;
      timer = 0;
      while (pending_angles.size() != 0 && timer < 100000) begin
         @(negedge clock);
         timer++;
      end
      repeat (Latency + 20) @(negedge clock);
      if (fails == 0 && pending_angles.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off counted here
   initial begin
      int held;
      bit done_hold;
      held = 0;
      done_hold = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rx && !done_hold && held < 400) begin
            rsp_tready <= 1'b0;
            held++;
            if (held == 400) done_hold = 1'b1;
         end else
            rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
      end
   end

   always @(posedge clock) begin
      logic [15:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_angles.size() == 0) begin
            $error("unexpected word angle=%0d", $signed(rsp_tdata));
            fails++;
         end else begin
            want = pending_angles.pop_front();
            if (rsp_tdata !== want) begin
               $error("angle: expected %0d, got %0d", $signed(want), $signed(rsp_tdata));
               fails++;
            end
         end
      end
   end

endmodule
